>>> design/schs_pkg.sv
// Package for the serial camera host sequencer: phase codes, result codes,
// operation codes and frame constants. No dependencies.
`default_nettype none
package schs_pkg;
  localparam int unsigned MaxPacketBytes = 1024;
  localparam int unsigned PlW = 11;

  typedef enum logic [2:0] {
    OP_RX = 3'd0, OP_TICK = 3'd1, OP_SYNC = 3'd2, OP_CAPTURE = 3'd3,
    OP_FETCH = 3'd4, OP_EXIT = 3'd5
  } op_e;

  typedef enum logic [8:0] {
    PH_IDLE = 9'b000000001, PH_SYNC_ACK = 9'b000000010, PH_SYNC_FRAME = 9'b000000100,
    PH_INIT_ACK = 9'b000001000, PH_SIZE_ACK = 9'b000010000, PH_SNAP_ACK = 9'b000100000,
    PH_GET_ACK = 9'b001000000, PH_LEN_FRAME = 9'b010000000, PH_DATA = 9'b100000000
  } phase_e;

  typedef enum logic [5:0] {
    SQ_IDLE = 6'b000001, SQ_CMD = 6'b000010, SQ_DIV = 6'b000100,
    SQ_EMIT = 6'b001000, SQ_STAT = 6'b010000, SQ_WAIT = 6'b100000
  } seq_e;

  localparam logic [1:0] KindTx = 2'd0;
  localparam logic [1:0] KindPay = 2'd1;
  localparam logic [1:0] KindStat = 2'd2;

  localparam logic [2:0] StSynced = 3'd0;
  localparam logic [2:0] StCaptured = 3'd1;
  localparam logic [2:0] StGood = 3'd2;
  localparam logic [2:0] StRetry = 3'd3;
  localparam logic [2:0] StFailed = 3'd4;

  localparam logic [2:0] RegAddr = 3'd0;
  localparam logic [2:0] RegFormat = 3'd1;
  localparam logic [2:0] RegPktLen = 3'd2;
  localparam logic [2:0] RegAckTo = 3'd3;
  localparam logic [2:0] RegDataTo = 3'd4;
  localparam logic [2:0] RegRetry = 3'd5;

  localparam logic [7:0] SyncByte = 8'haa;
  localparam logic [7:0] IdAck = 8'h0e;
  localparam logic [7:0] IdSync = 8'h0d;
  localparam logic [7:0] IdData = 8'h0a;
  localparam logic [7:0] IdInit = 8'h01;
  localparam logic [7:0] IdSize = 8'h06;
  localparam logic [7:0] IdSnap = 8'h05;
  localparam logic [7:0] IdGet = 8'h04;
  localparam logic [7:0] IdGetData = 8'h0e;
  localparam logic [7:0] FmtJpeg = 8'h07;
  localparam logic [7:0] ExitArg = 8'hf0;
endpackage
`default_nettype wire

>>> design/serial_camera_host_sequencer.sv
// Top level of the serial camera host sequencer: protocol phases, command
// emission, frame matching and a serial shift-subtract divider. Uses schs_pkg.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    operation, rx_byte, packet_index
//  out      out  out_valid/out_ready  kind, data_byte, status, picture_length,
//                                     packet_count, payload_length, last
//  cfg      in   cfg_we_i             cfg_index_i, cfg_data_i
//
// One transaction at a time: after acceptance the sequencer passes through SQ_EMIT
// and SQ_WAIT before it is ready again, with SQ_CMD to build a command, SQ_STAT to
// judge a finished packet and the serial divider (SQ_DIV) for the capture report
// (one quotient bit per cycle); each result is emitted from SQ_EMIT.
// Reset clears phase, counters and the config registers to their defaults.
// Output stalls hold the sequencer; input is not ready until the last result goes.
`default_nettype none
module serial_camera_host_sequencer
  import schs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [15:0] packet_index_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [2:0]       status_o,
  output logic [23:0]      picture_length_o,
  output logic [15:0]      packet_count_o,
  output logic [9:0]       payload_length_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic [2:0]  dev_q;
  logic [7:0]  fmt_q, retry_q;
  logic [10:0] plen_q;
  logic [15:0] ackto_q, datato_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= '0; fmt_q <= FmtJpeg; plen_q <= 11'd512;
      ackto_q <= 16'd100; datato_q <= 16'd1000; retry_q <= 8'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegAddr:   dev_q <= cfg_data_i[2:0];
        RegFormat: fmt_q <= cfg_data_i[7:0];
        RegPktLen: plen_q <= cfg_data_i[10:0];
        RegAckTo:  ackto_q <= cfg_data_i;
        RegDataTo: datato_q <= cfg_data_i;
        RegRetry:  retry_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Clamp packet length to 8..MaxPacketBytes.
  logic [10:0] eff_len;
  always_comb begin
    if (plen_q < 11'd8) eff_len = 11'd8;
    else if (plen_q > PlW'(MaxPacketBytes)) eff_len = PlW'(MaxPacketBytes);
    else eff_len = plen_q;
  end
  logic [7:0] addr_bits;
  assign addr_bits = {dev_q, 5'd0};

  // Protocol state.
  phase_e      phase_q, phase_d;
  seq_e        seq_q, seq_d;
  logic [10:0] fpos_q, fpos_d;
  logic [15:0] idle_q, idle_d;
  logic [23:0] lenr_q, lenr_d;
  logic [7:0]  sum_q, sum_d, dl0_q, dl0_d, dl1_q, dl1_d;
  logic [7:0]  att_q, att_d;
  logic [15:0] fidx_q, fidx_d;
  logic        mis_q, mis_d;

  // Pending work for the emitter.
  logic        cmd_q, cmd_d;          // command queued
  logic [7:0]  c1_q, c1_d, c2_q, c2_d, c3_q, c3_d, c4_q, c4_d, c5_q, c5_d;
  logic [2:0]  cidx_q, cidx_d;
  logic        pay_q, pay_d;          // payload byte queued
  logic [7:0]  payb_q, payb_d;
  logic        st_q, st_d;            // status queued (after command when synced)
  logic [2:0]  stc_q, stc_d;
  logic        stfirst_q, stfirst_d;  // status goes before the command
  logic [9:0]  paylen_q, paylen_d;
  logic        div_q, div_d;          // capture division queued
  logic [4:0]  dcnt_q, dcnt_d;
  logic [23:0] quo_q, quo_d;
  logic [10:0] rem_q, rem_d;

  // Output register.
  logic        ov_q, ov_d;
  logic [1:0]  ok_q, ok_d;
  logic [7:0]  ob_q, ob_d;
  logic [2:0]  os_q, os_d;
  logic [23:0] opl_q, opl_d;
  logic [15:0] opc_q, opc_d;
  logic [9:0]  opy_q, opy_d;
  logic        ol_q, ol_d;

  assign in_ready  = (seq_q == SQ_IDLE) && !ov_q;
  assign out_valid = ov_q;
  assign kind_o = ok_q; assign data_byte_o = ob_q; assign status_o = os_q;
  assign picture_length_o = opl_q; assign packet_count_o = opc_q;
  assign payload_length_o = opy_q; assign last_o = ol_q;

  logic [7:0] exp_v;
  logic       exp_ok;
  logic [2:0] p;
  logic [7:0] id;
  logic [9:0] pay;
  logic [11:0] trial;
  logic [15:0] lim;
  logic [7:0] att_inc;
  logic [10:0] np;

  always_comb begin
    phase_d = phase_q; seq_d = seq_q; fpos_d = fpos_q; idle_d = idle_q;
    lenr_d = lenr_q; sum_d = sum_q; dl0_d = dl0_q; dl1_d = dl1_q;
    att_d = att_q; fidx_d = fidx_q; mis_d = mis_q;
    cmd_d = cmd_q; c1_d = c1_q; c2_d = c2_q; c3_d = c3_q; c4_d = c4_q; c5_d = c5_q;
    cidx_d = cidx_q; pay_d = pay_q; payb_d = payb_q; st_d = st_q; stc_d = stc_q;
    stfirst_d = stfirst_q; paylen_d = paylen_q; div_d = div_q; dcnt_d = dcnt_q;
    quo_d = quo_q; rem_d = rem_q;
    ov_d = ov_q; ok_d = ok_q; ob_d = ob_q; os_d = os_q; opl_d = opl_q;
    opc_d = opc_q; opy_d = opy_q; ol_d = ol_q;
    exp_v = '0; exp_ok = 1'b0; id = IdGet;
    p = (fpos_q >= 11'd6) ? 3'd5 : fpos_q[2:0];
    pay = 10'(eff_len - 11'd6);
    trial = {rem_q, quo_q[23]} - {2'b00, pay};
    lim = (phase_q == PH_DATA || phase_q == PH_LEN_FRAME) ? datato_q : ackto_q;
    att_inc = (att_q < 8'd255) ? att_q + 8'd1 : att_q;
    np = fpos_q + 11'd1;

    if (ov_q && out_ready) ov_d = 1'b0;

    // Sequencer: SQ_CMD below queues the command for phase_q and clears frame state.
    case (seq_q)
      SQ_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_d = 1'b0; pay_d = 1'b0; st_d = 1'b0; div_d = 1'b0;
          stfirst_d = 1'b0; cidx_d = '0; seq_d = SQ_EMIT;
          case (operation_i)
            OP_SYNC, OP_CAPTURE, OP_FETCH: begin
              if (operation_i == OP_FETCH) begin
                att_d = '0; fidx_d = packet_index_i;
              end
              phase_d = (operation_i == OP_SYNC) ? PH_SYNC_ACK :
                        (operation_i == OP_CAPTURE) ? PH_INIT_ACK : PH_DATA;
              seq_d = SQ_CMD;
            end
            OP_EXIT: begin
              cmd_d = 1'b1; c1_d = IdAck; c2_d = '0; c3_d = '0;
              c4_d = ExitArg; c5_d = ExitArg;
              phase_d = PH_IDLE; fpos_d = '0; idle_d = '0; sum_d = '0;
              dl0_d = '0; dl1_d = '0; mis_d = 1'b0;
            end
            OP_TICK: begin
              if (phase_q != PH_IDLE) begin
                if (idle_q < 16'hffff) idle_d = idle_q + 16'd1;
                if (((idle_q < 16'hffff) ? idle_q + 16'd1 : idle_q) >= lim) begin
                  if (phase_q == PH_DATA) seq_d = SQ_STAT;
                  else begin
                    phase_d = (phase_q == PH_SYNC_FRAME) ? PH_SYNC_ACK :
                              (phase_q == PH_LEN_FRAME) ? PH_GET_ACK : phase_q;
                    seq_d = SQ_CMD;
                  end
                end
              end
            end
            OP_RX: begin
              if (phase_q == PH_DATA) begin
                if (fpos_q >= 11'd2) begin
                  sum_d = sum_q + dl1_q;
                  if (fpos_q >= 11'd6) begin pay_d = 1'b1; payb_d = dl1_q; end
                end
                dl1_d = dl0_q; dl0_d = rx_byte_i; fpos_d = np; idle_d = '0;
                if (np >= eff_len) seq_d = SQ_STAT;
              end else if (phase_q != PH_IDLE) begin
                case (phase_q)
                  PH_SYNC_ACK: id = IdSync;
                  PH_INIT_ACK: id = IdInit;
                  PH_SIZE_ACK: id = IdSize;
                  PH_SNAP_ACK: id = IdSnap;
                  default: id = IdGet;
                endcase
                if (p == 3'd0) begin exp_ok = 1'b1; exp_v = SyncByte; end
                else if (phase_q == PH_SYNC_FRAME) begin
                  exp_ok = 1'b1; exp_v = (p == 3'd1) ? (IdSync | addr_bits) : 8'd0;
                end else if (phase_q == PH_LEN_FRAME) begin
                  exp_ok = (p == 3'd1) || (p == 3'd2);
                  exp_v = (p == 3'd1) ? (IdData | addr_bits) : IdInit;
                end else begin
                  exp_ok = (p != 3'd3);
                  exp_v = (p == 3'd1) ? (IdAck | addr_bits) : (p == 3'd2) ? id : 8'd0;
                end
                mis_d = mis_q | (exp_ok && exp_v != rx_byte_i);
                if (phase_q == PH_LEN_FRAME && p >= 3'd3) begin
                  case (p)
                    3'd3: lenr_d[7:0] = rx_byte_i;
                    3'd4: lenr_d[15:8] = rx_byte_i;
                    default: lenr_d[23:16] = rx_byte_i;
                  endcase
                end
                fpos_d = {8'd0, p} + 11'd1; idle_d = '0;
                if (p == 3'd5) begin
                  fpos_d = '0; sum_d = '0; dl0_d = '0; dl1_d = '0; mis_d = 1'b0;
                  if (mis_q | (exp_ok && exp_v != rx_byte_i)) begin
                    phase_d = (phase_q == PH_SYNC_FRAME) ? PH_SYNC_ACK :
                              (phase_q == PH_LEN_FRAME) ? PH_GET_ACK : phase_q;
                    seq_d = SQ_CMD;
                  end else begin
                    case (phase_q)
                      PH_SYNC_ACK: phase_d = PH_SYNC_FRAME;
                      PH_SYNC_FRAME: begin
                        cmd_d = 1'b1; c1_d = IdAck; c2_d = IdSync; c3_d = '0;
                        c4_d = '0; c5_d = '0; st_d = 1'b1; stc_d = StSynced;
                        phase_d = PH_IDLE;
                      end
                      PH_INIT_ACK: begin phase_d = PH_SIZE_ACK; seq_d = SQ_CMD; end
                      PH_SIZE_ACK: begin phase_d = PH_SNAP_ACK; seq_d = SQ_CMD; end
                      PH_SNAP_ACK: begin phase_d = PH_GET_ACK; seq_d = SQ_CMD; end
                      PH_GET_ACK: phase_d = PH_LEN_FRAME;
                      default: begin
                        phase_d = PH_IDLE; st_d = 1'b1; stc_d = StCaptured;
                        div_d = 1'b1; dcnt_d = '0;
                        quo_d = (p == 3'd5) ? {rx_byte_i, lenr_q[15:0]} : lenr_q;
                        rem_d = '0; seq_d = SQ_DIV;
                      end
                    endcase
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      SQ_CMD: begin
        // Build command for phase_q and clear frame state.
        cmd_d = 1'b1; c2_d = '0; c3_d = '0; c4_d = '0; c5_d = '0;
        case (phase_q)
          PH_SYNC_ACK: c1_d = IdSync;
          PH_INIT_ACK: begin c1_d = IdInit; c3_d = FmtJpeg; c5_d = fmt_q; end
          PH_SIZE_ACK: begin
            c1_d = IdSize; c2_d = 8'h08; c3_d = eff_len[7:0]; c4_d = {5'd0, eff_len[10:8]};
          end
          PH_SNAP_ACK: c1_d = IdSnap;
          PH_GET_ACK: begin c1_d = IdGet; c2_d = 8'h01; end
          default: begin c1_d = IdGetData; c4_d = fidx_q[7:0]; c5_d = fidx_q[15:8]; end
        endcase
        fpos_d = '0; idle_d = '0; sum_d = '0; dl0_d = '0; dl1_d = '0; mis_d = 1'b0;
        seq_d = SQ_EMIT;
      end
      SQ_STAT: begin
        // Judge a finished data packet.
        st_d = 1'b1; fpos_d = '0; idle_d = '0; sum_d = '0; dl0_d = '0; dl1_d = '0;
        mis_d = 1'b0; seq_d = SQ_EMIT;
        if (fpos_q >= 11'd6 && sum_q == dl1_q) begin
          stc_d = StGood; paylen_d = 10'(fpos_q - 11'd6); phase_d = PH_IDLE;
        end else begin
          att_d = att_inc;
          if (att_inc < retry_q) begin
            stc_d = StRetry; stfirst_d = 1'b1; seq_d = SQ_CMD;
          end else begin
            stc_d = StFailed; phase_d = PH_IDLE;
          end
        end
      end
      SQ_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (!trial[11]) begin
          rem_d = trial[10:0]; quo_d = {quo_q[22:0], 1'b1};
        end else begin
          rem_d = {rem_q[9:0], quo_q[23]}; quo_d = {quo_q[22:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd23) seq_d = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (!ov_q || out_ready) begin
          ok_d = KindTx; ob_d = '0; os_d = '0; opl_d = '0; opc_d = '0; opy_d = '0;
          ol_d = 1'b0;
          if (pay_q) begin
            ov_d = 1'b1; ok_d = KindPay; ob_d = payb_q; pay_d = 1'b0;
            ol_d = !st_q && !cmd_q;
          end else if (st_q && (stfirst_q || !cmd_q)) begin
            ov_d = 1'b1; ok_d = KindStat; os_d = stc_q; st_d = 1'b0; stfirst_d = 1'b0;
            if (stc_q == StGood) opy_d = paylen_q;
            if (div_q) begin
              opl_d = lenr_q;
              opc_d = (quo_q[23:16] != 8'd0 || (quo_q[15:0] == 16'hffff && rem_q != 0))
                      ? 16'hffff : quo_q[15:0] + ((rem_q != 0) ? 16'd1 : 16'd0);
              div_d = 1'b0;
            end
            ol_d = !cmd_q;
          end else if (cmd_q) begin
            ov_d = 1'b1;
            case (cidx_q)
              3'd0: ob_d = SyncByte;
              3'd1: ob_d = addr_bits | c1_q;
              3'd2: ob_d = c2_q;
              3'd3: ob_d = c3_q;
              3'd4: ob_d = c4_q;
              default: ob_d = c5_q;
            endcase
            cidx_d = cidx_q + 3'd1;
            if (cidx_q == 3'd5) begin cmd_d = 1'b0; cidx_d = '0; ol_d = !st_q; end
          end else begin
            seq_d = SQ_WAIT;
          end
        end
      end
      SQ_WAIT: begin
        seq_d = SQ_IDLE;
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; seq_q <= SQ_IDLE; fpos_q <= '0; idle_q <= '0;
      lenr_q <= '0; sum_q <= '0; dl0_q <= '0; dl1_q <= '0; att_q <= '0;
      fidx_q <= '0; mis_q <= 1'b0; cmd_q <= 1'b0; cidx_q <= '0; pay_q <= 1'b0;
      st_q <= 1'b0; stfirst_q <= 1'b0; div_q <= 1'b0; dcnt_q <= '0; ov_q <= 1'b0;
    end else begin
      phase_q <= phase_d; seq_q <= seq_d; fpos_q <= fpos_d; idle_q <= idle_d;
      lenr_q <= lenr_d; sum_q <= sum_d; dl0_q <= dl0_d; dl1_q <= dl1_d;
      att_q <= att_d; fidx_q <= fidx_d; mis_q <= mis_d; cmd_q <= cmd_d;
      cidx_q <= cidx_d; pay_q <= pay_d; st_q <= st_d; stfirst_q <= stfirst_d;
      div_q <= div_d; dcnt_q <= dcnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= c1_d; c2_q <= c2_d; c3_q <= c3_d; c4_q <= c4_d; c5_q <= c5_d;
    payb_q <= payb_d; stc_q <= stc_d; paylen_q <= paylen_d; quo_q <= quo_d;
    rem_q <= rem_d; ok_q <= ok_d; ob_q <= ob_d; os_q <= os_d; opl_q <= opl_d;
    opc_q <= opc_d; opy_q <= opy_d; ol_q <= ol_d;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> (seq_q == SQ_IDLE && !ov_q)) else $error("ready while busy");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SQ_DIV |-> dcnt_q <= 5'd23) else $error("divider overrun");
  a_cidx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cidx_q <= 3'd5) else $error("command index out of range");
`endif

endmodule
`default_nettype wire

>>> test/schs_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the serial camera host sequencer: watches the input, output and
// register ports, predicts the result stream and compares it. Uses schs_pkg.
module schs_checker
  import schs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] packet_index_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [2:0]  status_i,
  input  logic [23:0] picture_length_i,
  input  logic [15:0] packet_count_i,
  input  logic [9:0]  payload_length_i,
  input  logic        last_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [23:0] pic_len;
    logic [15:0] pkt_cnt;
    logic [9:0]  pay_len;
    logic        last;
  } camera_result_t;

  camera_result_t expected_q[$];
  int             step_results;

  // register copies
  logic [2:0]  dev_addr;
  logic [7:0]  pic_fmt;
  logic [10:0] pkt_len;
  logic [15:0] ack_to, data_to;
  logic [7:0]  retry_lim;

  // sequencer state
  phase_e      phase;
  logic [15:0] frame_pos, idle_cnt, fetch_idx;
  logic [23:0] len_reg;
  logic [7:0]  sum_acc, dly0, dly1, attempts;
  logic        mismatch;

  function automatic int unsigned packet_bytes();
    int unsigned l;
    l = pkt_len;
    if (l < 8) l = 8;
    if (l > MaxPacketBytes) l = MaxPacketBytes;
    return l;
  endfunction

  function automatic void emit(logic [1:0] k, logic [7:0] d, logic [2:0] st,
                               logic [23:0] pl, logic [15:0] pc, logic [9:0] py);
    camera_result_t r;
    if (step_results >= 8) return;
    r = '{kind: k, data: d, status: st, pic_len: pl, pkt_cnt: pc, pay_len: py, last: 1'b0};
    expected_q.push_back(r);
    step_results++;
  endfunction

  function automatic void clear_frame();
    frame_pos = '0;
    idle_cnt = '0;
    sum_acc = '0;
    dly0 = '0;
    dly1 = '0;
    mismatch = 1'b0;
  endfunction

  function automatic void send_command(logic [7:0] code, logic [7:0] b2, logic [7:0] b3,
                                       logic [7:0] b4, logic [7:0] b5);
    emit(KindTx, SyncByte, '0, '0, '0, '0);
    emit(KindTx, {dev_addr, 5'd0} | code, '0, '0, '0, '0);
    emit(KindTx, b2, '0, '0, '0, '0);
    emit(KindTx, b3, '0, '0, '0, '0);
    emit(KindTx, b4, '0, '0, '0, '0);
    emit(KindTx, b5, '0, '0, '0, '0);
  endfunction

  function automatic void enter_phase(phase_e p);
    logic [15:0] l;
    l = 16'(packet_bytes());
    case (p)
      PH_SYNC_ACK: send_command(IdSync, 0, 0, 0, 0);
      PH_INIT_ACK: send_command(IdInit, 0, FmtJpeg, 0, pic_fmt);
      PH_SIZE_ACK: send_command(IdSize, 8'h08, l[7:0], l[15:8], 0);
      PH_SNAP_ACK: send_command(IdSnap, 0, 0, 0, 0);
      PH_GET_ACK:  send_command(IdGet, 8'h01, 0, 0, 0);
      PH_DATA:     send_command(IdGetData, 0, 0, fetch_idx[7:0], fetch_idx[15:8]);
      default: ;
    endcase
    phase = p;
    clear_frame();
  endfunction

  // Returns 1 when position p of the current frame has a fixed value.
  function automatic bit frame_byte_known(int unsigned p, output logic [7:0] v);
    logic [7:0] a, id;
    a = {dev_addr, 5'd0};
    v = '0;
    if (p == 0) begin
      v = SyncByte;
      return 1'b1;
    end
    if (phase == PH_SYNC_FRAME) begin
      v = (p == 1) ? (IdSync | a) : 8'h00;
      return 1'b1;
    end
    if (phase == PH_LEN_FRAME) begin
      if (p == 1) v = IdData | a;
      if (p == 2) v = 8'h01;
      return p <= 2;
    end
    case (phase)
      PH_SYNC_ACK: id = IdSync;
      PH_INIT_ACK: id = IdInit;
      PH_SIZE_ACK: id = IdSize;
      PH_SNAP_ACK: id = IdSnap;
      default:     id = IdGet;
    endcase
    if (p == 1) v = IdAck | a;
    else if (p == 2) v = id;
    return p != 3;
  endfunction

  function automatic void resend();
    if (phase == PH_SYNC_FRAME) enter_phase(PH_SYNC_ACK);
    else if (phase == PH_LEN_FRAME) enter_phase(PH_GET_ACK);
    else enter_phase(phase);
  endfunction

  function automatic void close_packet();
    if (frame_pos >= 6 && sum_acc == dly1) begin
      emit(KindStat, '0, StGood, '0, '0, 10'(frame_pos - 6));
      phase = PH_IDLE;
      clear_frame();
      return;
    end
    if (attempts < 8'd255) attempts++;
    if (attempts < retry_lim) begin
      emit(KindStat, '0, StRetry, '0, '0, '0);
      enter_phase(PH_DATA);
    end else begin
      emit(KindStat, '0, StFailed, '0, '0, '0);
      phase = PH_IDLE;
      clear_frame();
    end
  endfunction

  function automatic void take_data_byte(logic [7:0] b);
    if (frame_pos >= 2) begin
      sum_acc = sum_acc + dly1;
      if (frame_pos >= 6) emit(KindPay, dly1, '0, '0, '0, '0);
    end
    dly1 = dly0;
    dly0 = b;
    frame_pos++;
    idle_cnt = '0;
    if (frame_pos >= packet_bytes()) close_packet();
  endfunction

  function automatic void take_frame_byte(logic [7:0] b);
    logic [7:0]  v;
    int unsigned p, pay, q;
    p = (frame_pos >= 6) ? 5 : frame_pos;
    if (frame_byte_known(p, v) && v != b) mismatch = 1'b1;
    if (phase == PH_LEN_FRAME && p >= 3) len_reg[(p - 3) * 8 +: 8] = b;
    frame_pos = 16'(p + 1);
    idle_cnt = '0;
    if (frame_pos < 6) return;
    if (mismatch) begin
      resend();
      return;
    end
    case (phase)
      PH_SYNC_ACK: begin
        phase = PH_SYNC_FRAME;
        clear_frame();
      end
      PH_SYNC_FRAME: begin
        send_command(IdAck, IdSync, 0, 0, 0);
        emit(KindStat, '0, StSynced, '0, '0, '0);
        phase = PH_IDLE;
        clear_frame();
      end
      PH_INIT_ACK: enter_phase(PH_SIZE_ACK);
      PH_SIZE_ACK: enter_phase(PH_SNAP_ACK);
      PH_SNAP_ACK: enter_phase(PH_GET_ACK);
      PH_GET_ACK: begin
        phase = PH_LEN_FRAME;
        clear_frame();
      end
      default: begin
        pay = packet_bytes() - 6;
        q = len_reg / pay;
        if (len_reg % pay != 0) q++;
        if (q > 32'hffff) q = 32'hffff;
        emit(KindStat, '0, StCaptured, len_reg, 16'(q), '0);
        phase = PH_IDLE;
        clear_frame();
      end
    endcase
  endfunction

  function automatic void take_tick();
    logic [15:0] lim;
    if (phase == PH_IDLE) return;
    if (idle_cnt != 16'hffff) idle_cnt++;
    lim = (phase == PH_DATA || phase == PH_LEN_FRAME) ? data_to : ack_to;
    if (idle_cnt < lim) return;
    if (phase == PH_DATA) close_packet();
    else resend();
  endfunction

  function automatic void predict(logic [2:0] op, logic [7:0] b, logic [15:0] idx);
    step_results = 0;
    case (op)
      OP_RX: begin
        if (phase == PH_DATA) take_data_byte(b);
        else if (phase != PH_IDLE) take_frame_byte(b);
      end
      OP_TICK:    take_tick();
      OP_SYNC:    enter_phase(PH_SYNC_ACK);
      OP_CAPTURE: enter_phase(PH_INIT_ACK);
      OP_FETCH: begin
        attempts = '0;
        fetch_idx = idx;
        enter_phase(PH_DATA);
      end
      OP_EXIT: begin
        send_command(IdAck, 0, 0, ExitArg, ExitArg);
        phase = PH_IDLE;
        clear_frame();
      end
      default: ;
    endcase
    if (step_results > 0) expected_q[$].last = 1'b1;
  endfunction

  function automatic void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    camera_result_t e;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o = 0;
      dev_addr = '0;
      pic_fmt = FmtJpeg;
      pkt_len = 11'd512;
      ack_to = 16'd100;
      data_to = 16'd1000;
      retry_lim = 8'd100;
      phase = PH_IDLE;
      clear_frame();
      len_reg = '0;
      attempts = '0;
      fetch_idx = '0;
    end else begin
      // older results leave before a new transaction adds to the queue
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: kind %0d data %0h", kind_i, data_byte_i);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          compare_field("kind", e.kind, kind_i);
          compare_field("data_byte", e.data, data_byte_i);
          compare_field("status", e.status, status_i);
          compare_field("picture_length", e.pic_len, picture_length_i);
          compare_field("packet_count", e.pkt_cnt, packet_count_i);
          compare_field("payload_length", e.pay_len, payload_length_i);
          compare_field("last", e.last, last_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegAddr:   dev_addr = cfg_data_i[2:0];
          RegFormat: pic_fmt = cfg_data_i[7:0];
          RegPktLen: pkt_len = cfg_data_i[10:0];
          RegAckTo:  ack_to = cfg_data_i;
          RegDataTo: data_to = cfg_data_i;
          RegRetry:  retry_lim = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict(operation_i, rx_byte_i, packet_index_i);
    end
    pending_o = expected_q.size();
  end

endmodule

>>> test/tb_serial_camera_host_sequencer.sv
`timescale 1ns / 100ps
// Testbench top for the serial camera host sequencer: clock, reset, register
// setup and protocol stimulus. Depends on schs_pkg and schs_checker.
module tb_serial_camera_host_sequencer;
  import schs_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation_i = OP_TICK;
  logic [7:0]  rx_byte_i = '0;
  logic [15:0] packet_index_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  status_o;
  logic [23:0] picture_length_o;
  logic [15:0] packet_count_o;
  logic [9:0]  payload_length_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = RegAddr;
  logic [15:0] cfg_data_i = '0;

  int fail_count, pending;

  // idling percentages for each side and byte corruption rate
  int src_idle = 38;
  int sink_idle = 56;
  int corrupt_pct = 0;
  int tick_pct = 0;
  int n_items = 0;

  // local copies of what was last written, to build well-formed frames
  logic [2:0]  cur_addr = '0;
  logic [10:0] cur_pkt_len = 11'd512;
  logic [15:0] cur_data_to = 16'd1000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  serial_camera_host_sequencer u_top (
    .clk_i, .rst_ni, .in_valid, .in_ready, .operation_i, .rx_byte_i, .packet_index_i,
    .out_valid, .out_ready, .kind_o, .data_byte_o, .status_o, .picture_length_o,
    .packet_count_o, .payload_length_o, .last_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  schs_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i, .rx_byte_i, .packet_index_i,
    .out_valid_i(out_valid), .out_ready_i(out_ready), .kind_i(kind_o),
    .data_byte_i(data_byte_o), .status_i(status_o), .picture_length_i(picture_length_o),
    .packet_count_i(packet_count_o), .payload_length_i(payload_length_o), .last_i(last_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // Stall the result side at random; a new decision every falling edge.
  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= sink_idle);

  // Present one transaction and hold it until accepted, then maybe idle.
  // Called at a falling edge and returns at one.
  task automatic push_item(input logic [2:0] op, input logic [7:0] b, input logic [15:0] idx);
    in_valid <= 1'b1;
    operation_i <= op;
    rx_byte_i <= b;
    packet_index_i <= idx;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    n_items++;
    if ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // Feed a received byte, occasionally corrupted or preceded by a tick.
  task automatic rx(input logic [7:0] b);
    if ($urandom_range(99) < tick_pct) push_item(OP_TICK, 8'($urandom), 16'($urandom));
    if ($urandom_range(99) < corrupt_pct) b = 8'($urandom);
    push_item(OP_RX, b, 16'($urandom));
  endtask

  task automatic ack_frame(input logic [7:0] id);
    rx(SyncByte);
    rx(IdAck | {cur_addr, 5'd0});
    rx(id);
    rx(8'($urandom));
    rx(8'h00);
    rx(8'h00);
  endtask

  task automatic run_sync();
    push_item(OP_SYNC, 8'($urandom), 16'($urandom));
    ack_frame(IdSync);
    rx(SyncByte);
    rx(IdSync | {cur_addr, 5'd0});
    repeat (4) rx(8'h00);
  endtask

  task automatic run_capture(input logic [23:0] len);
    push_item(OP_CAPTURE, 8'($urandom), 16'($urandom));
    ack_frame(IdInit);
    ack_frame(IdSize);
    ack_frame(IdSnap);
    ack_frame(IdGet);
    rx(SyncByte);
    rx(IdData | {cur_addr, 5'd0});
    rx(8'h01);
    rx(len[7:0]);
    rx(len[15:8]);
    rx(len[23:16]);
  endtask

  // One data packet: the byte before the last carries the sum of all
  // earlier ones. Short packets are closed by ticks when the timeout is small.
  task automatic run_packet(input int nbytes, input int eff);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < nbytes; i++) begin
      if (i == nbytes - 2) begin
        rx(sum);
      end else begin
        logic [7:0] b;
        b = 8'($urandom);
        if (i < nbytes - 2) sum += b;
        rx(b);
      end
    end
    if (nbytes < eff && cur_data_to <= 16)
      repeat (cur_data_to) push_item(OP_TICK, 8'($urandom), 16'($urandom));
  endtask

  task automatic run_fetch();
    int eff, nbytes;
    eff = (cur_pkt_len < 8) ? 8 : (cur_pkt_len > MaxPacketBytes) ? MaxPacketBytes : cur_pkt_len;
    push_item(OP_FETCH, 8'($urandom), 16'($urandom));
    // further packets answer the block's own retries
    repeat ($urandom_range(1, 3)) begin
      if (eff <= 40 && $urandom_range(99) < 70) nbytes = eff;
      else nbytes = $urandom_range(0, (eff < 13) ? eff - 1 : 12);
      run_packet(nbytes, eff);
    end
  endtask

  // Drop valid, wait until every expected result has arrived, then let the
  // divider and any result-free transaction settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic setup(input logic [2:0] addr, input logic [7:0] fmt, input logic [10:0] plen,
                       input logic [15:0] ato, input logic [15:0] dto, input logic [7:0] rlim);
    drain();
    write_reg(RegAddr, 16'(addr));
    write_reg(RegFormat, 16'(fmt));
    write_reg(RegPktLen, 16'(plen));
    write_reg(RegAckTo, ato);
    write_reg(RegDataTo, dto);
    write_reg(RegRetry, 16'(rlim));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    cur_addr = addr;
    cur_pkt_len = plen;
    cur_data_to = dto;
  endtask

  // Mix of well-formed sequences and noise until the item count is reached.
  task automatic random_phase(input int until_items);
    int pick;
    logic [23:0] len;
    while (n_items < until_items) begin
      // shift the idling pattern as the run goes on
      if (n_items >= 200) begin
        src_idle = 0;
        sink_idle = 0;
      end else if (n_items >= 100) begin
        src_idle = 56;
        sink_idle = 38;
      end
      pick = $urandom_range(99);
      if (pick < 25) begin
        run_sync();
      end else if (pick < 50) begin
        case ($urandom_range(3))
          0: len = '0;
          1: len = 24'hffffff;
          default: len = 24'($urandom);
        endcase
        run_capture(len);
      end else if (pick < 85) begin
        run_fetch();
      end else begin
        repeat ($urandom_range(1, 4)) push_item(3'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle inputs, unknown operations, exit, a clean sync and
    // fetches at both ends of the packet number
    push_item(OP_RX, 8'hff, 16'h0000);
    push_item(OP_RX, 8'h00, 16'hffff);
    push_item(OP_TICK, 8'h00, 16'h0000);
    push_item(3'd6, 8'h5a, 16'h1234);
    push_item(3'd7, 8'ha5, 16'hedcb);
    push_item(OP_EXIT, 8'h00, 16'h0000);
    run_sync();
    push_item(OP_FETCH, 8'h00, 16'hffff);
    push_item(OP_EXIT, 8'hff, 16'h0000);
    push_item(OP_FETCH, 8'hff, 16'h0000);
    push_item(OP_SYNC, 8'h00, 16'h0000);

    // sweep register settings, extremes included, with a drain before each
    corrupt_pct = 3;
    tick_pct = 4;
    setup(3'd7, 8'h00, 11'd8, 16'd1, 16'd1, 8'd1);
    random_phase(75);
    setup(3'd0, 8'hff, 11'd2047, 16'd65535, 16'd65535, 8'd255);
    random_phase(125);
    // hold the sender off until the block has delivered everything
    drain();
    random_phase(140);
    setup(3'd5, 8'ha5, 11'd3, 16'd4, 16'd6, 8'd0);
    random_phase(195);
    setup(3'd2, 8'h07, 11'd20, 16'd3, 16'd3, 8'd3);
    random_phase(255);
    setup(3'd3, 8'h01, 11'd1024, 16'd100, 16'd16, 8'd4);
    random_phase(310);

    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
